// ===== sv/cpsr_pkg.sv =====
// ----------------------------------------------------------------------------
// Chunked page stream receiver package
// Opcodes, result kinds, protocol bytes and the CRC-16/CCITT-FALSE byte step.
// ----------------------------------------------------------------------------
package cpsr_pkg;

  localparam int CPSR_CHUNK_BYTES     = 32;
  localparam int CPSR_CHUNKS_PER_PAGE = 8;

  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_BYTE    = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;
  localparam logic [1:0] OP_READ    = 2'd3;

  localparam logic [1:0] KIND_HOST       = 2'd0;
  localparam logic [1:0] KIND_PAGE_READY = 2'd1;
  localparam logic [1:0] KIND_READ_DATA  = 2'd2;

  localparam logic [7:0]  HDR_ACK     = 8'h06;
  localparam logic [7:0]  HDR_END     = 8'h03;
  localparam logic [7:0]  HDR_DONE    = 8'h01;
  localparam logic [7:0]  ERASED_BYTE = 8'hFF;
  localparam logic [15:0] CRC_SEED    = 16'hFFFF;

  // One byte of CRC-16/CCITT-FALSE (poly 0x1021, MSB first), table-free form.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                             input logic [7:0]  data);
    logic [7:0] x;
    x = crc[15:8] ^ data;
    x = x ^ (x >> 4);
    return {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000} ^
           {8'h00, x};
  endfunction

endpackage

// ===== sv/cpsr_cmd_if.sv =====
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel that carries one command item to the receiver.
// ----------------------------------------------------------------------------
interface cpsr_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] program_number;
  logic [7:0] page_number;
  logic [7:0] rx_byte;
  logic [7:0] read_index;

  modport source (output valid, opcode, program_number, page_number, rx_byte,
                  read_index, input ready);
  modport sink (input valid, opcode, program_number, page_number, rx_byte,
                read_index, output ready);
endinterface

// ===== sv/cpsr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one result item from the receiver.
// ----------------------------------------------------------------------------
interface cpsr_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [7:0] commit_program;
  logic [7:0] commit_page;
  logic       last;

  modport source (output valid, kind, out_byte, commit_program, commit_page, last,
                  input ready);
  modport sink (input valid, kind, out_byte, commit_program, commit_page, last,
                output ready);
endinterface

// ===== sv/chunked_page_stream_receiver_top.sv =====
// ----------------------------------------------------------------------------
// Chunked page stream receiver
// Buffers one page of streamed bytes and reports a CRC byte per chunk.
// ----------------------------------------------------------------------------
// Items enter on cmd (start, received byte, timeout, buffer read) and results
// leave on rsp; each result marks the final one of its command with last.
// A start gives four host bytes (06, program, page, 03). A byte that closes a
// chunk gives the low CRC byte; the byte that closes the page adds a
// page-ready result and 06 01 program page 03, seven results in all. A read
// gives one data result. Other bytes and timeouts give no result.
// The first result of an item is shown in the cycle after it is
// accepted. A command is taken every cycle while the result register is
// empty or drains its final result in that cycle, so a stream of bytes runs
// at one per cycle and a command with N results occupies the result register
// until all N have been taken. The rate is set by that single result register and by the
// one-write, one-read page RAM with its registered read port.
// Reset clears the stream state and the result register; the page RAM is not
// cleared, a fill count marks bytes not yet received in this stream, which
// read as FF. While rsp is stalled the pending result holds, and cmd ready
// stays low until its final result has been taken.
// ----------------------------------------------------------------------------
module chunked_page_stream_receiver_top #(
  parameter int CHUNK_BYTES     = cpsr_pkg::CPSR_CHUNK_BYTES,
  parameter int CHUNKS_PER_PAGE = cpsr_pkg::CPSR_CHUNKS_PER_PAGE
) (
  input  logic       clk,
  input  logic       rst,
  cpsr_cmd_if.sink   cmd,
  cpsr_rsp_if.source rsp
);
  import cpsr_pkg::*;

  localparam int PAGE_BYTES = CHUNK_BYTES * CHUNKS_PER_PAGE;
  localparam int ADDR_W     = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
  localparam int CNT_W      = $clog2(PAGE_BYTES + 1);
  localparam int POS_W      = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
  localparam int CMP_W      = (CNT_W > 8) ? CNT_W : 8;

  typedef enum logic [1:0] {JOB_START, JOB_CRC, JOB_COMMIT, JOB_READ} job_t;
  typedef enum logic [1:0] {RD_MEM, RD_ERASED, RD_NONE} rd_src_t;

  logic             job_valid;
  job_t             job;
  logic [2:0]       step;
  logic [7:0]       job_crc;
  rd_src_t          rd_src;
  logic [CNT_W-1:0] byte_count;
  logic [POS_W-1:0] chunk_pos;
  logic [15:0]      running_crc;
  logic             streaming;
  logic [7:0]       held_program;
  logic [7:0]       held_page;

  logic             cmd_acc;
  logic             rsp_acc;
  logic             rsp_last;
  logic             byte_take;
  logic             chunk_end;
  logic             page_end;
  logic             job_load;
  logic [15:0]      crc_next;
  logic [CMP_W-1:0] idx_ext;
  logic [7:0]       mem_data;

  assign cmd_acc   = cmd.valid && cmd.ready;
  assign rsp_acc   = rsp.valid && rsp.ready;
  assign cmd.ready = !job_valid || (rsp.ready && rsp_last);
  assign byte_take = cmd_acc && (cmd.opcode == OP_BYTE) && streaming;
  assign chunk_end = (chunk_pos == POS_W'(CHUNK_BYTES - 1));
  assign page_end  = (byte_count == CNT_W'(PAGE_BYTES - 1));
  assign crc_next  = crc16_byte(running_crc, cmd.rx_byte);
  assign idx_ext   = CMP_W'(cmd.read_index);

  // An accepted item that produces at least one result loads the result register.
  assign job_load  = (cmd_acc && ((cmd.opcode == OP_START) || (cmd.opcode == OP_READ))) ||
                     (byte_take && chunk_end);

  cpsr_page_buf #(
    .DEPTH  (PAGE_BYTES),
    .ADDR_W (ADDR_W)
  ) u_page_buf (
    .clk     (clk),
    .wr_en   (byte_take),
    .wr_addr (ADDR_W'(byte_count)),
    .wr_data (cmd.rx_byte),
    .rd_en   (cmd_acc && (cmd.opcode == OP_READ)),
    .rd_addr (ADDR_W'(cmd.read_index)),
    .rd_data (mem_data)
  );

  // Result sequencer: the pending job and its step select the current item.
  always_comb begin
    rsp.kind           = KIND_HOST;
    rsp.out_byte       = 8'h00;
    rsp.commit_program = 8'h00;
    rsp.commit_page    = 8'h00;
    rsp_last           = 1'b0;
    case (job)
      JOB_START: begin
        case (step)
          3'd0:    rsp.out_byte = HDR_ACK;
          3'd1:    rsp.out_byte = held_program;
          3'd2:    rsp.out_byte = held_page;
          default: begin
            rsp.out_byte = HDR_END;
            rsp_last     = 1'b1;
          end
        endcase
      end
      JOB_CRC: begin
        rsp.out_byte = job_crc;
        rsp_last     = 1'b1;
      end
      JOB_COMMIT: begin
        case (step)
          3'd0: rsp.out_byte = job_crc;
          3'd1: begin
            rsp.kind           = KIND_PAGE_READY;
            rsp.commit_program = held_program;
            rsp.commit_page    = held_page;
          end
          3'd2:    rsp.out_byte = HDR_ACK;
          3'd3:    rsp.out_byte = HDR_DONE;
          3'd4:    rsp.out_byte = held_program;
          3'd5:    rsp.out_byte = held_page;
          default: begin
            rsp.out_byte = HDR_END;
            rsp_last     = 1'b1;
          end
        endcase
      end
      default: begin
        rsp.kind = KIND_READ_DATA;
        case (rd_src)
          RD_MEM:    rsp.out_byte = mem_data;
          RD_ERASED: rsp.out_byte = ERASED_BYTE;
          default:   rsp.out_byte = 8'h00;
        endcase
        rsp_last = 1'b1;
      end
    endcase
  end

  assign rsp.valid = job_valid;
  assign rsp.last  = rsp_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid    <= 1'b0;
      step         <= 3'd0;
      byte_count   <= '0;
      chunk_pos    <= '0;
      running_crc  <= CRC_SEED;
      streaming    <= 1'b0;
      held_program <= 8'h00;
      held_page    <= 8'h00;
    end else begin
      if (job_load) begin
        job_valid <= 1'b1;
      end else if (rsp_acc && rsp_last) begin
        job_valid <= 1'b0;
      end
      if (rsp_acc && !rsp_last) begin
        step <= step + 3'd1;
      end
      if (cmd_acc) begin
        unique case (cmd.opcode)
          OP_START: begin
            held_program <= cmd.program_number;
            held_page    <= cmd.page_number;
            byte_count   <= '0;
            chunk_pos    <= '0;
            running_crc  <= CRC_SEED;
            streaming    <= 1'b1;
            job          <= JOB_START;
            step         <= 3'd0;
          end
          OP_BYTE: begin
            if (streaming) begin
              byte_count <= byte_count + CNT_W'(1);
              if (chunk_end) begin
                chunk_pos   <= '0;
                running_crc <= CRC_SEED;
                job_crc     <= crc_next[7:0];
                step        <= 3'd0;
                if (page_end) begin
                  streaming <= 1'b0;
                  job       <= JOB_COMMIT;
                end else begin
                  job <= JOB_CRC;
                end
              end else begin
                chunk_pos   <= chunk_pos + POS_W'(1);
                running_crc <= crc_next;
              end
            end
          end
          OP_TIMEOUT: begin
            byte_count  <= '0;
            chunk_pos   <= '0;
            running_crc <= CRC_SEED;
            streaming   <= 1'b0;
          end
          OP_READ: begin
            // Entries at or past the fill count hold erased data this stream.
            if (idx_ext >= CMP_W'(PAGE_BYTES)) begin
              rd_src <= RD_NONE;
            end else if (idx_ext >= CMP_W'(byte_count)) begin
              rd_src <= RD_ERASED;
            end else begin
              rd_src <= RD_MEM;
            end
            job  <= JOB_READ;
            step <= 3'd0;
          end
        endcase
      end
    end
  end

endmodule

// ===== sv/cpsr_page_buf.sv =====
// ----------------------------------------------------------------------------
// Page buffer
// Single-port-write, single-port-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module cpsr_page_buf #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/cpsr_checker.sv =====
// ----------------------------------------------------------------------------
// Chunked page stream receiver checker
// Port-level assertions on the receiver, attached to the top level by bind.
// ----------------------------------------------------------------------------
module cpsr_checker (
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input logic [1:0] cmd_opcode,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [1:0] rsp_kind,
  input logic [7:0] rsp_out_byte,
  input logic [7:0] rsp_commit_program,
  input logic [7:0] rsp_commit_page,
  input logic       rsp_last
);
  import cpsr_pkg::*;

  // A stalled result item keeps its payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_out_byte) && $stable(rsp_last)))
    else $error("result item changed while stalled");

  // Commit fields are only populated on page-ready results.
  a_commit_fields: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_kind != KIND_PAGE_READY) |->
      (rsp_commit_program == 8'h00 && rsp_commit_page == 8'h00))
    else $error("commit fields set on a non page-ready result");

  // A start answers with the header opening byte in the next cycle.
  a_start_header: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready && cmd_opcode == OP_START) |=>
      (rsp_valid && rsp_kind == KIND_HOST && rsp_out_byte == HDR_ACK && !rsp_last))
    else $error("start did not open with the header byte");

  // A buffer read answers with a single read-data result in the next cycle.
  a_read_reply: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready && cmd_opcode == OP_READ) |=>
      (rsp_valid && rsp_kind == KIND_READ_DATA && rsp_last))
    else $error("buffer read did not give one read-data result");

endmodule

bind chunked_page_stream_receiver_top cpsr_checker u_cpsr_checker (
  .clk                (clk),
  .rst                (rst),
  .cmd_valid          (cmd.valid),
  .cmd_ready          (cmd.ready),
  .cmd_opcode         (cmd.opcode),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_kind           (rsp.kind),
  .rsp_out_byte       (rsp.out_byte),
  .rsp_commit_program (rsp.commit_program),
  .rsp_commit_page    (rsp.commit_page),
  .rsp_last           (rsp.last)
);

// ===== tb/sv/chunked_page_stream_receiver_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked page stream receiver testbench
// Drives start, byte, timeout and read items into the receiver with bursty
// input and a stalling result side. A scoreboard mirrors the page buffer,
// the per-chunk CRC-16/CCITT-FALSE and the stream state, and compares every
// result item with the oldest expected one.
// ----------------------------------------------------------------------------
module chunked_page_stream_receiver_top_test;
  import cpsr_pkg::*;

  localparam int PAGE_BYTES   = CPSR_CHUNK_BYTES * CPSR_CHUNKS_PER_PAGE;
  localparam int RANDOM_ITEMS = 470;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] program_number;
    logic [7:0] page_number;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [7:0] commit_program;
    logic [7:0] commit_page;
    logic       last;
  } result_item_t;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

  class page_stream_scoreboard;
    bit [7:0]     page_image [PAGE_BYTES];
    int unsigned  bytes_taken;
    bit [15:0]    chunk_crc;
    bit           in_stream;
    bit [7:0]     latched_program;
    bit [7:0]     latched_page;
    result_item_t staged_results[$];
    result_item_t expected_results[$];
    int           mismatches;

    function new();
      foreach (page_image[i]) page_image[i] = 8'h00;
      bytes_taken     = 0;
      chunk_crc       = CRC_SEED;
      in_stream       = 1'b0;
      latched_program = 8'h00;
      latched_page    = 8'h00;
      mismatches      = 0;
    endfunction

    // Bitwise MSB-first CRC-16 with polynomial 0x1021.
    function bit [15:0] crc_ccitt_step(bit [15:0] crc, bit [7:0] data);
      bit [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
        c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
      end
      return c;
    endfunction

    function void erase_page();
      foreach (page_image[i]) page_image[i] = ERASED_BYTE;
      bytes_taken   = 0;
      chunk_crc     = CRC_SEED;
      in_stream     = 1'b0;
    endfunction

    function void stage(logic [1:0] kind, logic [7:0] data, logic [7:0] prog,
                        logic [7:0] page);
      result_item_t r;
      r.kind           = kind;
      r.out_byte       = data;
      r.commit_program = prog;
      r.commit_page    = page;
      r.last           = 1'b0;
      staged_results.push_back(r);
    endfunction

    // Updates the mirrored state for one accepted item and queues its results.
    // Returns 0 for a byte that the receiver drops.
    function bit note_cmd(cmd_item_t c);
      bit taken;
      taken = 1'b1;
      staged_results.delete();
      case (c.opcode)
        OP_START: begin
          erase_page();
          latched_program = c.program_number;
          latched_page    = c.page_number;
          in_stream       = 1'b1;
          stage(KIND_HOST, HDR_ACK, 8'h00, 8'h00);
          stage(KIND_HOST, latched_program, 8'h00, 8'h00);
          stage(KIND_HOST, latched_page, 8'h00, 8'h00);
          stage(KIND_HOST, HDR_END, 8'h00, 8'h00);
        end
        OP_BYTE: begin
          if (!in_stream || bytes_taken >= PAGE_BYTES) begin
            taken = 1'b0;
          end else begin
            page_image[bytes_taken] = c.rx_byte;
            bytes_taken++;
            chunk_crc = crc_ccitt_step(chunk_crc, c.rx_byte);
            if (bytes_taken % CPSR_CHUNK_BYTES == 0) begin
              stage(KIND_HOST, chunk_crc[7:0], 8'h00, 8'h00);
              chunk_crc = CRC_SEED;
              if (bytes_taken >= PAGE_BYTES) begin
                in_stream = 1'b0;
                stage(KIND_PAGE_READY, 8'h00, latched_program, latched_page);
                stage(KIND_HOST, HDR_ACK, 8'h00, 8'h00);
                stage(KIND_HOST, HDR_DONE, 8'h00, 8'h00);
                stage(KIND_HOST, latched_program, 8'h00, 8'h00);
                stage(KIND_HOST, latched_page, 8'h00, 8'h00);
                stage(KIND_HOST, HDR_END, 8'h00, 8'h00);
              end
            end
          end
        end
        OP_TIMEOUT: begin
          erase_page();
        end
        default: begin
          stage(KIND_READ_DATA, (c.read_index < PAGE_BYTES) ? page_image[c.read_index] :
                8'h00, 8'h00, 8'h00);
        end
      endcase
      if (staged_results.size() > 0) staged_results[$].last = 1'b1;
      foreach (staged_results[i]) expected_results.push_back(staged_results[i]);
      return taken;
    endfunction

    function void compare_field(string name, int unsigned expected, int unsigned actual);
      if (expected != actual) begin
        $error("%s: expected %0h, actual %0h", name, expected, actual);
        mismatches++;
      end
    endfunction

    function void check_result(result_item_t actual);
      result_item_t expected;
      if (expected_results.size() == 0) begin
        $error("result item with none expected: kind %0d byte %0h", actual.kind,
               actual.out_byte);
        mismatches++;
      end else begin
        expected = expected_results.pop_front();
        compare_field("kind", expected.kind, actual.kind);
        compare_field("out_byte", expected.out_byte, actual.out_byte);
        compare_field("commit_program", expected.commit_program, actual.commit_program);
        compare_field("commit_page", expected.commit_page, actual.commit_page);
        compare_field("last", expected.last, actual.last);
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  cpsr_cmd_if cmd_ch ();
  cpsr_rsp_if rsp_ch ();

  chunked_page_stream_receiver_top DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  page_stream_scoreboard sb;
  int          burst_left;
  int          items_counted;
  int          cycle_count;
  int          stall_left;
  stall_mode_t stall_mode;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_item_t r;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      r.kind           = rsp_ch.kind;
      r.out_byte       = rsp_ch.out_byte;
      r.commit_program = rsp_ch.commit_program;
      r.commit_page    = rsp_ch.commit_page;
      r.last           = rsp_ch.last;
      sb.check_result(r);
    end
  end

  // The result side switches between randomly chosen stall patterns, each held for a random run.
  initial begin
    rsp_ch.ready = 1'b0;
    stall_left   = 0;
    stall_mode   = STALL_NONE;
    forever begin
      @(posedge clk);
      if (stall_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        stall_left = $urandom_range(16, 96);
      end
      stall_left--;
      case (stall_mode)
        STALL_NONE:     rsp_ch.ready <= 1'b1;
        STALL_RANDOM:   rsp_ch.ready <= 1'($urandom_range(0, 1));
        STALL_PERIODIC: rsp_ch.ready <= (stall_left % 5) > 2;
        default:        rsp_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_cmd(input logic [1:0] op, input logic [7:0] prog,
                          input logic [7:0] page, input logic [7:0] data,
                          input logic [7:0] idx);
    cmd_item_t c;
    c.opcode         = op;
    c.program_number = prog;
    c.page_number    = page;
    c.rx_byte        = data;
    c.read_index     = idx;
    cmd_ch.valid          <= 1'b1;
    cmd_ch.opcode         <= op;
    cmd_ch.program_number <= prog;
    cmd_ch.page_number    <= page;
    cmd_ch.rx_byte        <= data;
    cmd_ch.read_index     <= idx;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    if (sb.note_cmd(c)) items_counted++;
    if (burst_left == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200) :
                   $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_random_read();
    send_cmd(OP_READ, rnd8(), rnd8(), rnd8(), rnd8());
  endtask

  // Holds the sender off until every outstanding result item has arrived.
  task automatic wait_for_results();
    cmd_ch.valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (sb.pending() != 0);
  endtask

  // One start followed by a full page or a partial one, with reads mixed in.
  task automatic run_stream(input bit full_page);
    int n;
    send_cmd(OP_START, rnd8(), rnd8(), rnd8(), rnd8());
    n = full_page ? PAGE_BYTES : $urandom_range(1, 96);
    // A partial stream stays within the items still to be sent.
    if (!full_page && n > RANDOM_ITEMS - items_counted) n = RANDOM_ITEMS - items_counted;
    for (int i = 0; i < n; i++) begin
      send_cmd(OP_BYTE, rnd8(), rnd8(), rnd8(), rnd8());
      if ($urandom_range(0, 99) < 6) send_random_read();
    end
    if (full_page) begin
      repeat ($urandom_range(1, 4)) send_random_read();
      if ($urandom_range(0, 1)) send_cmd(OP_BYTE, rnd8(), rnd8(), rnd8(), rnd8());
    end else begin
      case ($urandom_range(0, 2))
        0: send_cmd(OP_TIMEOUT, rnd8(), rnd8(), rnd8(), rnd8());
        1: send_random_read();
        default: ;
      endcase
    end
  endtask

  initial begin
    bit first_stream;
    rst                   = 1'b1;
    burst_left            = 3;
    items_counted         = 0;
    cmd_ch.valid          = 1'b0;
    cmd_ch.opcode         = OP_TIMEOUT;
    cmd_ch.program_number = 8'h00;
    cmd_ch.page_number    = 8'h00;
    cmd_ch.rx_byte        = 8'h00;
    cmd_ch.read_index     = 8'h00;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Timeout with no stream first, so the reads right after it see erased bytes.
    send_cmd(OP_TIMEOUT, 8'h00, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_READ, 8'h00, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_READ, 8'h00, 8'h00, 8'h00, 8'hFF);
    send_cmd(OP_BYTE, 8'h00, 8'h00, 8'h5A, 8'h00);
    send_cmd(OP_START, 8'h00, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_START, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_cmd(OP_BYTE, 8'h00, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_BYTE, 8'h00, 8'h00, 8'hFF, 8'h00);
    send_cmd(OP_BYTE, 8'h00, 8'h00, 8'hA5, 8'h00);
    send_cmd(OP_READ, 8'h00, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_READ, 8'h00, 8'h00, 8'h00, 8'h01);
    send_cmd(OP_READ, 8'h00, 8'h00, 8'h00, 8'h02);
    send_cmd(OP_READ, 8'h00, 8'h00, 8'h00, 8'h03);
    send_cmd(OP_TIMEOUT, 8'h00, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_READ, 8'h00, 8'h00, 8'h00, 8'h01);
    send_cmd(OP_BYTE, 8'h00, 8'h00, 8'h33, 8'h00);
    send_cmd(OP_START, 8'h81, 8'h7E, 8'h00, 8'h00);
    send_cmd(OP_BYTE, 8'h00, 8'h00, 8'h42, 8'h00);
    wait_for_results();

    items_counted = 0;
    first_stream  = 1'b1;
    while (items_counted < RANDOM_ITEMS) begin
      if (first_stream || $urandom_range(0, 99) < 60) begin
        // After the first stream, a full page is only started while enough items remain for it.
        run_stream(first_stream || ((RANDOM_ITEMS - items_counted > PAGE_BYTES + 8) &&
                                    ($urandom_range(0, 99) < 55)));
        if (first_stream) wait_for_results();
        first_stream = 1'b0;
      end else begin
        case ($urandom_range(0, 2))
          0: send_cmd(OP_BYTE, rnd8(), rnd8(), rnd8(), rnd8());
          1: send_cmd(OP_TIMEOUT, rnd8(), rnd8(), rnd8(), rnd8());
          default: send_random_read();
        endcase
      end
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== chunked_page_stream_receiver_top.f =====
sv/cpsr_pkg.sv
sv/cpsr_cmd_if.sv
sv/cpsr_rsp_if.sv
sv/cpsr_page_buf.sv
sv/chunked_page_stream_receiver_top.sv
sv/cpsr_checker.sv
tb/sv/chunked_page_stream_receiver_top_test.sv
